>>> src/vram_hblank_general_dma_control_core_macros.svh
// Assertion macros for the video-memory DMA block.
`ifndef VRAM_HBLANK_GENERAL_DMA_CONTROL_CORE_MACROS_SVH
`define VRAM_HBLANK_GENERAL_DMA_CONTROL_CORE_MACROS_SVH

// Checked only out of reset.
`define VHGDMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define VHGDMA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> src/vhgdma_pkg.sv
`default_nettype none

package vhgdma_pkg;

  typedef enum logic [2:0] {
    OP_SRC_HI = 3'd0,
    OP_SRC_LO = 3'd1,
    OP_DST_HI = 3'd2,
    OP_DST_LO = 3'd3,
    OP_CMD    = 3'd4,
    OP_BLANK  = 3'd5
  } opcode_e;

  localparam logic [8:0]  SETUP_CYCLES   = 9'd460;
  localparam logic [12:0] BLOCK_BYTES    = 13'd16;
  localparam logic [2:0]  VRAM_BASE_HI   = 3'b100;
  localparam logic [7:0]  STATUS_IDLE    = 8'hFF;

  // Address registers kept only as wide as the bits that form an address.
  typedef struct packed {
    logic [7:0] src_hi;
    logic [3:0] src_lo;
    logic [4:0] dst_hi;
    logic [3:0] dst_lo;
    logic [7:0] status;
    logic [7:0] mode;
  } state_t;

  typedef struct packed {
    logic        copy_valid;
    logic [15:0] copy_source;
    logic [15:0] copy_dest;
    logic [11:0] copy_length;
    logic [11:0] stall_cycles;
    logic [12:0] timer_ticks;
    logic [7:0]  status_value;
  } result_t;

endpackage

`default_nettype wire

>>> src/vhgdma_if.sv
`default_nettype none

interface vhgdma_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] reg_data;

  modport source (output valid, output opcode, output reg_data, input ready);
  modport sink (input valid, input opcode, input reg_data, output ready);
endinterface

interface vhgdma_rsp_if;
  logic        valid;
  logic        ready;
  logic        copy_valid;
  logic [15:0] copy_source;
  logic [15:0] copy_dest;
  logic [11:0] copy_length;
  logic [11:0] stall_cycles;
  logic [12:0] timer_ticks;
  logic [7:0]  status_value;

  modport source (output valid, output copy_valid, output copy_source, output copy_dest,
                  output copy_length, output stall_cycles, output timer_ticks,
                  output status_value, input ready);
  modport sink (input valid, input copy_valid, input copy_source, input copy_dest,
                input copy_length, input stall_cycles, input timer_ticks,
                input status_value, output ready);
endinterface

interface vhgdma_cfg_if;
  logic valid;
  logic ready;
  logic double_speed;

  modport source (output valid, output double_speed, input ready);
  modport sink (input valid, input double_speed, output ready);
endinterface

`default_nettype wire

>>> src/vhgdma_exec.sv
`default_nettype none

module vhgdma_exec (
  input  var vhgdma_pkg::state_t  state_i,
  input  var logic [2:0]          opcode_i,
  input  var logic [7:0]          reg_data_i,
  input  var logic                double_speed_i,
  output var vhgdma_pkg::state_t  state_o,
  output var vhgdma_pkg::result_t result_o
);

  logic [8:0]  base;
  logic [15:0] src;
  logic [12:0] doff;
  logic [12:0] gen_len;
  logic [12:0] len;
  logic        do_copy;
  logic [12:0] stall;
  logic [13:0] ticks;
  logic [15:0] src_next;
  logic [12:0] doff_next;

  always_comb begin
    base    = double_speed_i ? (vhgdma_pkg::SETUP_CYCLES >> 1) : vhgdma_pkg::SETUP_CYCLES;
    src     = {state_i.src_hi, state_i.src_lo, 4'h0};
    doff    = {state_i.dst_hi, state_i.dst_lo, 4'h0};
    gen_len = {({1'b0, reg_data_i} + 9'd1), 4'h0};
    len     = '0;
    do_copy = 1'b0;
    stall   = '0;
    state_o = state_i;

    case (opcode_i)
      vhgdma_pkg::OP_SRC_HI: state_o.src_hi = reg_data_i;
      vhgdma_pkg::OP_SRC_LO: state_o.src_lo = reg_data_i[7:4];
      vhgdma_pkg::OP_DST_HI: state_o.dst_hi = reg_data_i[4:0];
      vhgdma_pkg::OP_DST_LO: state_o.dst_lo = reg_data_i[7:4];
      vhgdma_pkg::OP_CMD: begin
        if (state_i.mode[7] || reg_data_i[7]) begin
          state_o.mode   = reg_data_i;
          state_o.status = {1'b0, reg_data_i[6:0]};
          stall          = {4'h0, base};
        end else begin
          do_copy        = 1'b1;
          len            = gen_len;
          state_o.status = vhgdma_pkg::STATUS_IDLE;
          stall          = {4'h0, base} + gen_len;
        end
      end
      vhgdma_pkg::OP_BLANK: begin
        if (state_i.mode[7]) begin
          do_copy        = 1'b1;
          len            = vhgdma_pkg::BLOCK_BYTES;
          state_o.status = state_i.status - 8'd1;
          state_o.mode   = state_i.mode - 8'd1;
          stall          = vhgdma_pkg::BLOCK_BYTES;
        end
      end
      default: ;
    endcase

    src_next  = src + {3'b000, len};
    doff_next = doff + len;
    if (do_copy) begin
      state_o.src_hi = src_next[15:8];
      state_o.src_lo = src_next[7:4];
      state_o.dst_hi = doff_next[12:8];
      state_o.dst_lo = doff_next[7:4];
    end

    ticks = double_speed_i ? {stall, 1'b0} : {1'b0, stall};

    result_o              = '0;
    result_o.copy_valid   = do_copy;
    if (do_copy) begin
      result_o.copy_source = src;
      result_o.copy_dest   = {vhgdma_pkg::VRAM_BASE_HI, doff};
      result_o.copy_length = len[11:0];
    end
    result_o.stall_cycles = stall[11:0];
    result_o.timer_ticks  = ticks[12:0];
    result_o.status_value = state_o.status;
  end

endmodule

`default_nettype wire

>>> src/vram_hblank_general_dma_control_core.sv
// Video-memory DMA register block. Each request transaction is a byte write to the
// source or destination address registers, a command write, or a horizontal-blank
// event, and each yields exactly one response transaction: a copy descriptor
// (source, destination, length; zero when nothing is copied), the machine cycles
// consumed, the divider/timer advance and the status byte. One request is taken per
// cycle while the output register is empty or being drained; its response appears in
// the next cycle from that register. A single stage lies between the address/status
// and output registers. double_speed is written through the configuration channel;
// the user must do so only while the block is idle; the block does not enforce this.
`default_nettype none

module vram_hblank_general_dma_control_core (
  input  var logic       clk_i,
  input  var logic       rst_ni,
  vhgdma_cfg_if.sink     cfg_i,
  vhgdma_req_if.sink     req_i,
  vhgdma_rsp_if.source   rsp_o
);

  vhgdma_pkg::state_t  state_q, state_d;
  vhgdma_pkg::result_t result_q, result_d;
  logic                out_valid_q;
  logic                double_speed_q;
  logic                accept;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  vhgdma_exec u_exec (
    .state_i        (state_q),
    .opcode_i       (req_i.opcode),
    .reg_data_i     (req_i.reg_data),
    .double_speed_i (double_speed_q),
    .state_o        (state_d),
    .result_o       (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= '{status: vhgdma_pkg::STATUS_IDLE, default: '0};
      out_valid_q    <= 1'b0;
      double_speed_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        double_speed_q <= cfg_i.double_speed;
      end
      if (accept) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.copy_valid   = result_q.copy_valid;
  assign rsp_o.copy_source  = result_q.copy_source;
  assign rsp_o.copy_dest    = result_q.copy_dest;
  assign rsp_o.copy_length  = result_q.copy_length;
  assign rsp_o.stall_cycles = result_q.stall_cycles;
  assign rsp_o.timer_ticks  = result_q.timer_ticks;
  assign rsp_o.status_value = result_q.status_value;

endmodule

`default_nettype wire

>>> src/vhgdma_checker.sv
`default_nettype none
`include "vram_hblank_general_dma_control_core_macros.svh"

module vhgdma_checker (
  input var logic        clk_i,
  input var logic        rst_ni,
  input var logic        in_valid_i,
  input var logic        in_ready_i,
  input var logic        out_valid_i,
  input var logic        out_ready_i,
  input var logic [15:0] out_source_i,
  input var logic [15:0] out_dest_i,
  input var logic [7:0]  out_status_i
);

  `VHGDMA_ASSERT(a_rsp_hold,
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_source_i) &&
      $stable(out_dest_i) && $stable(out_status_i),
    "response dropped or changed under stall")
  `VHGDMA_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !out_valid_i,
    "response valid after reset edge")
  `VHGDMA_ASSERT(a_req_to_rsp, in_valid_i && in_ready_i |=> out_valid_i,
    "accepted request gave no response")
  `VHGDMA_ASSERT(a_ready_only_stall, !in_ready_i |-> out_valid_i && !out_ready_i,
    "request blocked without output stall")

endmodule

bind vram_hblank_general_dma_control_core vhgdma_checker u_vhgdma_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .out_source_i (rsp_o.copy_source),
  .out_dest_i   (rsp_o.copy_dest),
  .out_status_i (rsp_o.status_value)
);

`default_nettype wire
